### rtl/stcv_pkg.sv
// ----------------------------------------------------------------------------
// stcv_pkg
// Shared types and constants of the stick-to-cursor velocity block.
// ----------------------------------------------------------------------------
package stcv_pkg;

  // field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DZ_W    = 15;
  localparam int unsigned GAIN_W  = 16;

  // shared multiply-accumulate unit widths
  localparam int unsigned MUL_A_W = 20;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = MUL_P_W + 1;

  // smoothing product is Q0.16
  localparam int unsigned FRAC_SHIFT = 16;

  // saturation bounds of the Q8.8 velocity
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  // configuration register reset values
  localparam logic [DZ_W-1:0]   DEADZONE_RST = DZ_W'(8000);
  localparam logic [GAIN_W-1:0] FINE_RST     = GAIN_W'(1280);
  localparam logic [GAIN_W-1:0] COARSE_RST   = GAIN_W'(7680);
  localparam logic [GAIN_W-1:0] SMOOTH_RST   = GAIN_W'(13107);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_FINE     = 2'd1,
    REG_COARSE   = 2'd2,
    REG_SMOOTH   = 2'd3
  } reg_idx_e;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;     // capture a new result
    logic accum;  // add the product to the held value
  } mac_ctrl_t;

endpackage

### rtl/stcv_mac.sv
// ----------------------------------------------------------------------------
// stcv_mac
// Shared signed multiply-accumulate unit with a registered accumulator.
// ----------------------------------------------------------------------------
module stcv_mac (
  input  logic                                      clk_i,
  input  stcv_pkg::mac_ctrl_t                       ctrl_i,
  input  logic signed [stcv_pkg::MUL_A_W-1:0]       op_a_i,
  input  logic signed [stcv_pkg::MUL_B_W-1:0]       op_b_i,
  output logic signed [stcv_pkg::ACC_W-1:0]         acc_o
);
  import stcv_pkg::*;

  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc_d, acc_q;

  // product, optionally added to the held value
  always_comb begin
    prod  = op_a_i * op_b_i;
    acc_d = ACC_W'(prod) + (ctrl_i.accum ? acc_q : '0);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### rtl/stick_to_cursor_velocity.sv
// ----------------------------------------------------------------------------
// stick_to_cursor_velocity
// Deadzone, gain mixing and exponential smoothing of two sticks into a
// saturated Q8.8 cursor velocity, with buttons passed through as clicks.
// ----------------------------------------------------------------------------
// One input beat is taken at a time: after acceptance the block works
// through five steps per axis (plus one step to load the output
// register) and then takes the next beat. The pace is set by the single
// shared multiply-accumulate unit, which forms the six products of a beat
// (left gain, right gain and smoothing for X, then for Y) one after another.
// The result is held in an output register, so a new beat is taken while a
// finished result still waits; a result is only delayed if the previous one
// has not been taken by the time the next one is ready.
module stick_to_cursor_velocity #(
  parameter int unsigned AXIS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_x, left_y, right_x, right_y
  input  logic [1:0]  s_axis_tuser,   // south_button, shoulder_button
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // move_x, move_y
  output logic [1:0]  m_axis_tuser,   // left_click, right_click
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stcv_pkg::*;

  localparam int unsigned SHIFT = AXIS_BITS - 1;
  localparam int unsigned CMP_W = FIELD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT,
    ST_TARGET,
    ST_SCALE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // configuration registers
  logic [DZ_W-1:0]   dz_q;
  logic [GAIN_W-1:0] fine_q, coarse_q, smooth_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= DEADZONE_RST;
      fine_q   <= FINE_RST;
      coarse_q <= COARSE_RST;
      smooth_q <= SMOOTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEADZONE: dz_q     <= pwdata[DZ_W-1:0];
        REG_FINE:     fine_q   <= pwdata[GAIN_W-1:0];
        REG_COARSE:   coarse_q <= pwdata[GAIN_W-1:0];
        REG_SMOOTH:   smooth_q <= pwdata[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_DEADZONE: prdata = 32'(dz_q);
      REG_FINE:     prdata = 32'(fine_q);
      REG_COARSE:   prdata = 32'(coarse_q);
      REG_SMOOTH:   prdata = 32'(smooth_q);
      default:      prdata = '0;
    endcase
  end

  // deadzone on the four axes of the incoming beat
  logic signed [AXIS_BITS-1:0] raw   [4];
  logic signed [AXIS_BITS-1:0] gated [4];
  logic        [AXIS_BITS:0]   mag   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raw[i]   = s_axis_tdata[FIELD_W*i +: AXIS_BITS];
      mag[i]   = raw[i][AXIS_BITS-1] ? (AXIS_BITS + 1)'(-{raw[i][AXIS_BITS-1], raw[i]})
                                     : {1'b0, raw[i]};
      gated[i] = (CMP_W'(mag[i]) < CMP_W'(dz_q)) ? '0 : raw[i];
    end
  end

  // sequencer, held samples and velocity state
  state_e                      state_q;
  logic                        axis_q;
  logic                        s_acc, m_load;
  logic signed [AXIS_BITS-1:0] lx_q, ly_q, rx_q, ry_q;
  logic [1:0]                  btn_q;
  logic signed [FIELD_W-1:0]   vx_q, vy_q, v_cur, v_new;
  logic signed [MUL_A_W-1:0]   diff_q, diff_d;
  logic signed [FIELD_W-1:0]   out_x_q, out_y_q;
  logic [1:0]                  out_btn_q;
  logic                        m_valid_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign m_load        = (state_q == ST_DONE) & (~m_valid_q | m_axis_tready);
  assign v_cur         = axis_q ? vy_q : vx_q;

  // shared multiply-accumulate operands
  mac_ctrl_t                 mac_ctrl;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]   acc;

  always_comb begin
    mac_ctrl = '0;
    op_a     = diff_q;
    op_b     = MUL_B_W'(smooth_q);
    case (state_q)
      ST_LEFT: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0};
        op_a     = MUL_A_W'(axis_q ? ly_q : lx_q);
        op_b     = MUL_B_W'(fine_q);
      end
      ST_RIGHT: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b1};
        op_a     = MUL_A_W'(axis_q ? ry_q : rx_q);
        op_b     = MUL_B_W'(coarse_q);
      end
      ST_SCALE: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0};
      end
      default: ;
    endcase
  end

  stcv_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  // rounded target minus current velocity
  logic signed [ACC_W-1:0] tgt_r, tgt_diff;

  always_comb begin
    tgt_r    = (acc + (ACC_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
    tgt_diff = tgt_r - ACC_W'(v_cur);
    diff_d   = tgt_diff[MUL_A_W-1:0];
  end

  // rounded step, added and saturated
  logic signed [ACC_W-1:0] step_r, v_sum;

  always_comb begin
    step_r = (acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    v_sum  = step_r + ACC_W'(v_cur);
    if (v_sum > SAT_MAX) begin
      v_new = SAT_MAX[FIELD_W-1:0];
    end else if (v_sum < SAT_MIN) begin
      v_new = SAT_MIN[FIELD_W-1:0];
    end else begin
      v_new = v_sum[FIELD_W-1:0];
    end
  end

  // control state and velocity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= 1'b0;
      vx_q      <= '0;
      vy_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_LEFT;
            axis_q  <= 1'b0;
          end
        end
        ST_LEFT:   state_q <= ST_RIGHT;
        ST_RIGHT:  state_q <= ST_TARGET;
        ST_TARGET: state_q <= ST_SCALE;
        ST_SCALE:  state_q <= ST_UPDATE;
        ST_UPDATE: begin
          if (axis_q) begin
            vy_q    <= v_new;
            state_q <= ST_DONE;
          end else begin
            vx_q    <= v_new;
            axis_q  <= 1'b1;
            state_q <= ST_LEFT;
          end
        end
        ST_DONE: begin
          if (m_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      lx_q  <= gated[0];
      ly_q  <= gated[1];
      rx_q  <= gated[2];
      ry_q  <= gated[3];
      btn_q <= s_axis_tuser;
    end
    if (state_q == ST_TARGET) begin
      diff_q <= diff_d;
    end
    if (m_load) begin
      out_x_q   <= vx_q;
      out_y_q   <= vy_q;
      out_btn_q <= btn_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_btn_q;

endmodule

### rtl/stcv_checker.sv
// ----------------------------------------------------------------------------
// stcv_checker
// Port-level checks of the stick-to-cursor velocity block.
// ----------------------------------------------------------------------------
module stcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // the block stays busy for the cycles after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken again too early");

  // a new result appears only as the block finishes its work
  a_result_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
    else $error("result appeared outside the end of a computation");

  // a result does not appear right after an input beat is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result right after acceptance");

endmodule

bind stick_to_cursor_velocity stcv_checker u_stcv_checker (.*);
